>>> rtl/hcbp_pkg.sv
// ----------------------------------------------------------------------------
// hcbp_pkg
// Shared types and constants of the code bit packer: opcodes, field widths,
// code table entry and the item handed from the lookup stage to the packer.
// ----------------------------------------------------------------------------
package hcbp_pkg;

  localparam int MAX_CODE_LEN  = 32;
  localparam int ALPHABET_SIZE = 256;

  localparam int WORD_BITS   = 32;
  localparam int CODE_LIM    = (MAX_CODE_LEN < WORD_BITS) ? MAX_CODE_LEN : WORD_BITS;
  localparam int BYTE_W      = 8;
  localparam int PEND_W      = BYTE_W - 1;
  localparam int SYM_W       = 8;
  localparam int LEN_W       = 6;
  localparam int VBITS_W     = 4;
  localparam int TABLE_DEPTH = 1 << SYM_W;
  localparam int ACC_W       = PEND_W + CODE_LIM;
  localparam int TOT_W       = $clog2(ACC_W + 1);

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2
  } op_t;

  typedef struct packed {
    logic [CODE_LIM-1:0] code;
    logic [LEN_W-1:0]    len;
  } entry_t;

  typedef struct packed {
    logic   flush;
    entry_t entry;
  } item_t;

endpackage

>>> rtl/hcbp_code_ram.sv
// ----------------------------------------------------------------------------
// hcbp_code_ram
// Per-symbol code table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module hcbp_code_ram (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [hcbp_pkg::SYM_W-1:0] wr_addr,
  input  hcbp_pkg::entry_t          wr_data,
  input  logic                      rd_en,
  input  logic [hcbp_pkg::SYM_W-1:0] rd_addr,
  output hcbp_pkg::entry_t          rd_data
);

  hcbp_pkg::entry_t mem [hcbp_pkg::TABLE_DEPTH];
  hcbp_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // hold read data until the next lookup
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/hcbp_packer.sv
// ----------------------------------------------------------------------------
// hcbp_packer
// Bit accumulator and output register. Merges one looked-up code, extracts
// one full byte per cycle unless stalled; emits the zero-padded tail on flush.
// ----------------------------------------------------------------------------
module hcbp_packer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          item_valid,
  input  hcbp_pkg::item_t               item,
  output logic                          item_go,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [hcbp_pkg::BYTE_W-1:0]   out_byte,
  output logic [hcbp_pkg::VBITS_W-1:0]  out_valid_bits,
  output logic                          out_last_of_run
);

  localparam int TW = hcbp_pkg::TOT_W;
  localparam int AW = hcbp_pkg::ACC_W;
  localparam int BW = hcbp_pkg::BYTE_W;
  localparam int VW = hcbp_pkg::VBITS_W;

  logic [AW-1:0]  acc_r, acc_nxt;
  logic [TW-1:0]  tot_r, tot_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [BW-1:0]  out_byte_r, out_byte_nxt;
  logic [VW-1:0]  out_vbits_r, out_vbits_nxt;
  logic           out_last_r, out_last_nxt;

  logic           slot_free;
  logic           emit;
  logic [TW-1:0]  rem;
  logic           enc_go;
  logic           flush_go;
  logic           flush_out;
  logic [AW-1:0]  shifted;
  logic [BW-1:0]  flush_byte;
  logic [VW-1:0]  flush_sh;

  always_comb begin
    slot_free  = !out_valid_r || !out_stall;
    emit       = slot_free && (tot_r >= TW'(BW));
    rem        = emit ? (tot_r - TW'(BW)) : tot_r;
    enc_go     = item_valid && !item.flush && (rem < TW'(BW));
    flush_go   = item_valid && item.flush && (tot_r < TW'(BW)) &&
                 ((tot_r == '0) || slot_free);
    flush_out  = flush_go && (tot_r != '0);
    item_go    = enc_go || flush_go;

    shifted    = acc_r >> (tot_r - TW'(BW));
    flush_sh   = VW'(BW) - VW'(tot_r);
    flush_byte = acc_r[BW-1:0] << flush_sh;

    // bits above tot_r are don't-care; extraction and flush never look at them
    acc_nxt = acc_r;
    tot_nxt = rem;
    if (enc_go) begin
      acc_nxt = (acc_r << item.entry.len) | AW'(item.entry.code);
      tot_nxt = rem + TW'(item.entry.len);
    end else if (flush_go) begin
      tot_nxt = '0;
    end

    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_vbits_nxt = out_vbits_r;
    out_last_nxt  = out_last_r;
    priority if (emit) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = shifted[BW-1:0];
      out_vbits_nxt = VW'(BW);
      out_last_nxt  = (rem < TW'(BW));
    end else if (flush_out) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = flush_byte;
      out_vbits_nxt = VW'(tot_r);
      out_last_nxt  = 1'b1;
    end else if (slot_free) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tot_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      tot_r       <= tot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r       <= acc_nxt;
    out_byte_r  <= out_byte_nxt;
    out_vbits_r <= out_vbits_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_valid_bits  = out_vbits_r;
  assign out_last_of_run = out_last_r;

  a_tot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tot_r <= TW'(AW))
    else $error("pending bit count overflow");

  a_partial_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_vbits_r != VW'(BW)) |-> out_last_r)
    else $error("partial byte not marked last");

  a_full_byte_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (tot_r >= TW'(BW)) && slot_free |=> out_valid_r)
    else $error("full byte not moved to output");

  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    flush_go |=> (tot_r == '0))
    else $error("flush left pending bits");

endmodule

>>> rtl/huffman_code_bit_packer_top.sv
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_top
// Prefix-code encoder back end: code table load, symbol lookup, bit packing.
// ----------------------------------------------------------------------------
// Load beats write one symbol's code word and length into a 256-entry code
// table RAM. An encode beat reads the table at acceptance and, once the
// packer takes it, its code is appended MSB-first to the bit accumulator;
// each completed byte leaves through the output register, first code bit in
// bit 7, one byte per cycle while out_stall is low. A flush beat sends out
// the last partial byte, zero-padded in its low bits, with its count of
// valid bits. Every beat that produces bytes marks its final byte with
// out_last_of_run. The input takes one beat per cycle while each code
// completes at most one byte and out_stall is low; a code completing more
// bytes holds off the next code until the byte extractor leaves less than
// a full byte. A flush waits until the accumulator holds no full byte and,
// if bits are pending, the output register is free. Encoding a symbol whose
// table entry was never loaded gives undefined bytes.
// ----------------------------------------------------------------------------
module huffman_code_bit_packer_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_opcode,
  input  logic [hcbp_pkg::SYM_W-1:0]     in_symbol,
  input  logic [hcbp_pkg::WORD_BITS-1:0] in_code_bits,
  input  logic [hcbp_pkg::LEN_W-1:0]     in_code_length,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [hcbp_pkg::BYTE_W-1:0]    out_byte,
  output logic [hcbp_pkg::VBITS_W-1:0]   out_valid_bits,
  output logic                           out_last_of_run
);

  localparam int LIM = hcbp_pkg::CODE_LIM;
  localparam int LW  = hcbp_pkg::LEN_W;

  // lookup stage: one encode or flush beat waiting for the packer
  logic              s1_valid_r, s1_valid_nxt;
  logic              s1_flush_r, s1_flush_nxt;

  logic              in_acc;
  logic              in_alpha;
  logic              is_load;
  logic              is_enc;
  logic              is_flush;
  logic [LW-1:0]     len_sat;
  logic [LIM-1:0]    code_mask;
  hcbp_pkg::entry_t  wr_entry;
  hcbp_pkg::entry_t  rd_entry;
  hcbp_pkg::item_t   item;
  logic              item_go;

  always_comb begin
    in_alpha = ({1'b0, in_symbol} < (hcbp_pkg::SYM_W + 1)'(hcbp_pkg::ALPHABET_SIZE));
    is_load  = (in_opcode == hcbp_pkg::OP_LOAD);
    is_enc   = (in_opcode == hcbp_pkg::OP_ENCODE);
    is_flush = (in_opcode == hcbp_pkg::OP_FLUSH);

    // hold the beat while the lookup stage cannot hand its item on
    in_stall = s1_valid_r && !item_go;
    in_acc   = in_valid && !in_stall;

    // saturate the length and drop code bits above it before storing
    len_sat   = (in_code_length > LW'(LIM)) ? LW'(LIM) : in_code_length;
    code_mask = (len_sat == '0) ? '0 : ({LIM{1'b1}} >> (LW'(LIM) - len_sat));
    wr_entry.code = in_code_bits[LIM-1:0] & code_mask;
    wr_entry.len  = len_sat;

    // only encodes inside the alphabet and flushes go on; loads end here
    s1_valid_nxt = s1_valid_r;
    s1_flush_nxt = s1_flush_r;
    if (in_acc) begin
      s1_valid_nxt = (is_enc && in_alpha) || is_flush;
      s1_flush_nxt = is_flush;
    end else if (item_go) begin
      s1_valid_nxt = 1'b0;
    end

    item.flush = s1_flush_r;
    item.entry = rd_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_flush_r <= s1_flush_nxt;
  end

  // a load writes at its acceptance edge, so an encode accepted later
  // already reads the new entry: no forwarding needed
  hcbp_code_ram u_ram (
    .clk     (clk),
    .wr_en   (in_acc && is_load && in_alpha),
    .wr_addr (in_symbol),
    .wr_data (wr_entry),
    .rd_en   (in_acc && is_enc && in_alpha),
    .rd_addr (in_symbol),
    .rd_data (rd_entry)
  );

  hcbp_packer u_packer (
    .clk             (clk),
    .rst_n           (rst_n),
    .item_valid      (s1_valid_r),
    .item            (item),
    .item_go         (item_go),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_valid_bits  (out_valid_bits),
    .out_last_of_run (out_last_of_run)
  );

endmodule
